[src/ect_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ect_pkg;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_ZONE_OFFSET = 2'd0;
	localparam logic [1:0] REG_TWELVE_HOUR = 2'd1;
	localparam logic [1:0] REG_DAY_FIRST   = 2'd2;

	localparam int ZONE_W = 17;

	// Seconds per day is 2^7 * 675; (t >> 7) * DIV675_MUL >> 35 is exact for a 25-bit value.
	localparam logic [25:0] DIV675_MUL   = 26'd50903317;
	localparam int          DIV675_SHIFT = 35;
	localparam logic [16:0] SECS_PER_DAY = 17'd86400;

	// Days per four-year cycle, counted from 1969 so that the leap year comes last.
	localparam logic [16:0] DIV1461_MUL   = 17'd91868;
	localparam int          DIV1461_SHIFT = 27;
	localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;
	localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
	localparam logic [11:0] BASE_YEAR     = 12'd1969;

	// Seconds per hour is 2^4 * 225, seconds per minute is 2^2 * 15.
	localparam logic [13:0] DIV225_MUL   = 14'd9321;
	localparam int          DIV225_SHIFT = 21;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [10:0] DIV15_MUL    = 11'd1093;
	localparam int          DIV15_SHIFT  = 14;
	localparam logic [5:0]  SECS_PER_MIN = 6'd60;

	localparam logic [8:0]  LEAP_DAY_DOY = 9'd59;

	typedef struct packed {
		logic [11:0] year;
		logic [4:0]  month;
		logic [4:0]  day;
	} date_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic       pm;
	} hms_t;

	// First day index of each month in a common year.
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] d;
		unique case (m)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

[src/epoch_to_calendar_time.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// input     start, busy           epoch_seconds
// result    result_valid strobe   year, first_field, second_field, hour, minute,
//                                 second, pm_flag
// config    cfg_valid, cfg_ready  cfg_index, cfg_data
//
// A seven-stage pipeline: a timestamp can be started in every cycle and its result
// is strobed on result_valid. The stage count is set by the reciprocal multipliers
// (day, four-year cycle, hour, minute), each followed by a register.
// busy is always low and cfg_ready always high. arst_n clears the configuration
// registers and the valid pipeline; results are never held back.
module epoch_to_calendar_time (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output      logic                       busy,
	input  wire logic [31:0]                epoch_seconds,
	output      logic                       result_valid,
	output      logic [11:0]                year,
	output      logic [4:0]                 first_field,
	output      logic [4:0]                 second_field,
	output      logic [4:0]                 hour,
	output      logic [5:0]                 minute,
	output      logic [5:0]                 second,
	output      logic                       pm_flag,
	input  wire logic                       cfg_valid,
	output      logic                       cfg_ready,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [ect_pkg::ZONE_W-1:0] cfg_data
);
	import ect_pkg::*;

	logic [ZONE_W-1:0] zone_q;
	logic              twelve_q;
	logic              day_first_q;
	logic [6:0]        valid_q;

	logic [31:0] t_s1, t_s2;
	logic [15:0] days_s2, days_s3;
	logic [16:0] sod_s3;
	logic [50:0] dprod;
	logic [31:0] day_secs;
	date_t       date;
	hms_t        hms;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q      <= '0;
			twelve_q    <= 1'b0;
			day_first_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ZONE_OFFSET: zone_q      <= cfg_data;
				REG_TWELVE_HOUR: twelve_q    <= cfg_data[0];
				REG_DAY_FIRST:   day_first_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[5:0], start && !busy};
		end
	end

	assign dprod    = 51'(t_s1[31:7]) * 51'(DIV675_MUL);
	assign day_secs = 32'(days_s2) * 32'(SECS_PER_DAY);

	// The offset is sign-extended and the sum wraps at 32 bits.
	always_ff @(posedge clk) begin
		t_s1    <= epoch_seconds + {{(32 - ZONE_W){zone_q[ZONE_W-1]}}, zone_q};
		t_s2    <= t_s1;
		days_s2 <= dprod[DIV675_SHIFT +: 16];
		days_s3 <= days_s2;
		sod_s3  <= 17'(t_s2 - day_secs);
	end

	ect_date u_date (
		.clk  (clk),
		.days (days_s3),
		.date (date)
	);

	ect_clock u_clock (
		.clk         (clk),
		.sod         (sod_s3),
		.twelve_hour (twelve_q),
		.hms         (hms)
	);

	assign result_valid = valid_q[6];
	assign year         = date.year;
	assign first_field  = day_first_q ? date.day : date.month;
	assign second_field = day_first_q ? date.month : date.day;
	assign hour         = hms.hour;
	assign minute       = hms.minute;
	assign second       = hms.second;
	assign pm_flag      = hms.pm;

endmodule

`default_nettype wire

[src/ect_date.sv]
`timescale 1ns / 1ps
`default_nettype none

// Day count since 1970 to year, month and day over four pipeline stages.
module ect_date (
	input  wire logic          clk,
	input  wire logic [15:0]   days,
	output ect_pkg::date_t     date
);
	import ect_pkg::*;

	logic [15:0] x_s4;
	logic [5:0]  quad_s4, quad_s5;
	logic [10:0] rr_s5;
	logic [11:0] year_s6;
	logic [8:0]  doy_s6;
	logic        leap_s6;
	logic [4:0]  month_s7, day_s7;

	logic [15:0] x;
	logic [32:0] qprod;
	logic [16:0] qmul;
	logic [1:0]  k;
	logic [8:0]  doy;
	logic [8:0]  idx;
	logic [3:0]  m;
	logic [4:0]  month_n, day_n;

	assign x     = days + 16'(DAYS_PER_YEAR);
	assign qprod = 33'(x) * 33'(DIV1461_MUL);
	assign qmul  = 17'(quad_s4) * 17'(DAYS_PER_QUAD);

	always_comb begin
		priority if (rr_s5 >= 11'(3 * 365)) begin
			k = 2'd3;
		end else if (rr_s5 >= 11'(2 * 365)) begin
			k = 2'd2;
		end else if (rr_s5 >= 11'(365)) begin
			k = 2'd1;
		end else begin
			k = 2'd0;
		end
		doy = 9'(rr_s5 - 11'(k) * 11'(DAYS_PER_YEAR));
	end

	// In a leap year the day after February 28 is the leap day, and later days
	// fall back by one onto the common-year table.
	always_comb begin
		idx = doy_s6;
		if (leap_s6 && doy_s6 > LEAP_DAY_DOY) begin
			idx = doy_s6 - 9'd1;
		end
		m = 4'd0;
		for (int j = 1; j < 12; j++) begin
			if (idx >= month_start(4'(j))) begin
				m = 4'(j);
			end
		end
		month_n = 5'(m) + 5'd1;
		day_n   = 5'(idx - month_start(m)) + 5'd1;
		if (leap_s6 && doy_s6 == LEAP_DAY_DOY) begin
			month_n = 5'd2;
			day_n   = 5'd29;
		end
	end

	always_ff @(posedge clk) begin
		x_s4     <= x;
		quad_s4  <= qprod[DIV1461_SHIFT +: 6];
		rr_s5    <= 11'(17'(x_s4) - qmul);
		quad_s5  <= quad_s4;
		year_s6  <= BASE_YEAR + {4'd0, quad_s5, 2'd0} + 12'(k);
		doy_s6   <= doy;
		leap_s6  <= (k == 2'd3);
		month_s7 <= month_n;
		day_s7   <= day_n;
	end

	// The year is carried one more stage to line up with month and day.
	logic [11:0] year_s7;
	always_ff @(posedge clk) begin
		year_s7 <= year_s6;
	end

	assign date.year  = year_s7;
	assign date.month = month_s7;
	assign date.day   = day_s7;

endmodule

`default_nettype wire

[src/ect_clock.sv]
`timescale 1ns / 1ps
`default_nettype none

// Second of day to hour, minute and second over four pipeline stages.
module ect_clock (
	input  wire logic          clk,
	input  wire logic [16:0]   sod,
	input  wire logic          twelve_hour,
	output ect_pkg::hms_t      hms
);
	import ect_pkg::*;

	logic [16:0] sod_s4;
	logic [4:0]  hour_s4, hour_s5, hour_s6, hour_s7;
	logic [11:0] rem_s5, rem_s6;
	logic [5:0]  min_s6, min_s7, sec_s7;
	logic        pm_s7;

	logic [26:0] hprod;
	logic [20:0] mprod;
	logic [4:0]  hour_n;
	logic        pm_n;

	assign hprod = 27'(sod[16:4]) * 27'(DIV225_MUL);
	assign mprod = 21'(rem_s5[11:2]) * 21'(DIV15_MUL);

	always_comb begin
		hour_n = hour_s6;
		pm_n   = 1'b0;
		if (twelve_hour) begin
			if (hour_s6 == 5'd0) begin
				hour_n = 5'd12;
			end else if (hour_s6 >= 5'd12) begin
				pm_n = 1'b1;
				if (hour_s6 > 5'd12) begin
					hour_n = hour_s6 - 5'd12;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		sod_s4  <= sod;
		hour_s4 <= hprod[DIV225_SHIFT +: 5];
		rem_s5  <= 12'(sod_s4 - 17'(hour_s4) * 17'(SECS_PER_HOUR));
		hour_s5 <= hour_s4;
		min_s6  <= mprod[DIV15_SHIFT +: 6];
		rem_s6  <= rem_s5;
		hour_s6 <= hour_s5;
		sec_s7  <= 6'(rem_s6 - 12'(min_s6) * 12'(SECS_PER_MIN));
		min_s7  <= min_s6;
		hour_s7 <= hour_n;
		pm_s7   <= pm_n;
	end

	assign hms.hour   = hour_s7;
	assign hms.minute = min_s7;
	assign hms.second = sec_s7;
	assign hms.pm     = pm_s7;

endmodule

`default_nettype wire
